// ----- rtl/swgi_pkg.sv -----
// ----------------------------------------------------------------------------
// swgi_pkg
// Shared types and constants of the weighted gather interpolation core.
// ----------------------------------------------------------------------------
package swgi_pkg;

  localparam int unsigned BoundaryW = 2;
  localparam int unsigned NodeW     = 12;
  localparam int unsigned CompW     = 3;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned CfgW      = 4;
  localparam int unsigned AccW      = 48;
  localparam int unsigned ProdW     = 64;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 40;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpDonor = 1'b1;

  localparam logic [CfgW-1:0] NumCompReset = CfgW'(3);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_ACC  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

endpackage

// ----- rtl/swgi_ram.sv -----
// ----------------------------------------------------------------------------
// swgi_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module swgi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sparse_weighted_gather_interp_core.sv -----
// ----------------------------------------------------------------------------
// sparse_weighted_gather_interp_core
// Weighted gather interpolation with a source store and one shared MAC.
// ----------------------------------------------------------------------------
// Input transfers on the s_axis channel are either loads (tuser = 0), which
// write one Q16.16 source value into the store, or donor terms (tuser = 1),
// which add weight times the stored value into each active component's
// accumulator. A donor transfer with tlast set closes the target point: one
// result per active component leaves on m_axis in component order, the last
// one with tlast, and all accumulators are cleared.
// A load is written into the store when it is accepted. A donor is followed,
// for each active component in turn, by a store read, a multiply, and a round
// and saturating add, one component after another because of the single store
// read port and the single multiplier; a closing donor then emits the results
// in turn. The block accepts no transfer while a donor is in progress.
// Results pass through one output register; a stalled receiver holds the
// block in its emit phase. The cfg port sets the component count at any
// time and is always ready. Reset clears the accumulators, sets the count to
// three and leaves the store contents undefined; no clearing pass is run.
// ----------------------------------------------------------------------------
module sparse_weighted_gather_interp_core
  import swgi_pkg::*;
#(
  parameter int unsigned MAX_BOUNDARIES = 4,
  parameter int unsigned MAX_NODES      = 4096,
  parameter int unsigned MAX_COMPONENTS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // boundary, node, component, value, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // op
  input  logic [0:0]          s_axis_tuser_i,
  input  logic                s_axis_tlast_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // out_component, out_value, zero pad
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o
);

  localparam int unsigned Depth = MAX_BOUNDARIES * MAX_NODES * MAX_COMPONENTS;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned KW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int unsigned NW    = $clog2(MAX_COMPONENTS + 1);

  state_e state_q, state_d;
  logic [CfgW-1:0]   num_q;
  logic [KW-1:0]     k_q, k_d;
  logic [NW-1:0]     n_q, n_d;
  logic [AddrW-1:0]  base_q, base_d;
  logic [ValueW-1:0] weight_q, weight_d;
  logic              last_q, last_d;
  logic [ProdW-1:0]  prod_q;
  logic [AccW-1:0]   acc_q [MAX_COMPONENTS];
  logic              ov_q;
  logic [CompW-1:0]  oc_q;
  logic [ValueW-1:0] oval_q;
  logic              olast_q;

  logic [BoundaryW-1:0] in_bd;
  logic [NodeW-1:0]     in_node;
  logic [CompW-1:0]     in_comp;
  logic [ValueW-1:0]    in_val;
  logic                 in_acc, addr_ok, comp_ok, ram_we, ram_re;
  logic [AddrW-1:0]     in_base, ram_waddr, ram_raddr;
  logic [ValueW-1:0]    ram_rdata;
  logic [NW-1:0]        n_eff;
  logic                 k_end, out_load;
  logic [ProdW-1:0]     rounded;
  logic [AccW:0]        sum;
  logic [AccW-1:0]      acc_new, acc_k;
  logic [ValueW-1:0]    sat_out;

  assign in_bd   = s_axis_tdata_i[1:0];
  assign in_node = s_axis_tdata_i[13:2];
  assign in_comp = s_axis_tdata_i[16:14];
  assign in_val  = s_axis_tdata_i[48:17];

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign addr_ok = (32'(in_bd) < MAX_BOUNDARIES) && (32'(in_node) < MAX_NODES);
  assign comp_ok = 32'(in_comp) < MAX_COMPONENTS;
  assign in_base = AddrW'((32'(in_bd) * MAX_NODES + 32'(in_node)) * MAX_COMPONENTS);

  always_comb begin
    if (num_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(num_q) > MAX_COMPONENTS) begin
      n_eff = NW'(MAX_COMPONENTS);
    end else begin
      n_eff = NW'(num_q);
    end
  end

  assign ram_we    = in_acc && (s_axis_tuser_i[0] == OpLoad) && addr_ok && comp_ok;
  assign ram_waddr = in_base + AddrW'(in_comp);
  assign ram_re    = (state_q == S_READ);
  assign ram_raddr = base_q + AddrW'(k_q);

  swgi_ram #(
    .Width(ValueW),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(in_val),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign k_end    = (NW'(k_q) == NW'(n_q - NW'(1)));
  assign out_load = (state_q == S_EMIT) && (!ov_q || m_axis_tready_i);
  assign acc_k    = acc_q[k_q];

  assign rounded = prod_q + ProdW'(64'd1 << 29);
  assign sum     = {acc_k[AccW-1], acc_k} + (AccW+1)'($signed(rounded[ProdW-1:30]));

  always_comb begin
    if (sum[AccW] != sum[AccW-1]) begin
      acc_new = sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_new = sum[AccW-1:0];
    end
  end

  always_comb begin
    if (acc_k[AccW-1:ValueW-1] != {(AccW-ValueW+1){acc_k[AccW-1]}}) begin
      sat_out = acc_k[AccW-1] ? {1'b1, {(ValueW-1){1'b0}}} : {1'b0, {(ValueW-1){1'b1}}};
    end else begin
      sat_out = acc_k[ValueW-1:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    n_d      = n_q;
    base_d   = base_q;
    weight_d = weight_q;
    last_d   = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && (s_axis_tuser_i[0] == OpDonor)) begin
          k_d      = '0;
          n_d      = n_eff;
          base_d   = in_base;
          weight_d = in_val;
          last_d   = s_axis_tlast_i;
          if (addr_ok) begin
            state_d = S_READ;
          end else if (s_axis_tlast_i) begin
            state_d = S_EMIT;
          end
        end
      end
      S_READ: state_d = S_MUL;
      S_MUL:  state_d = S_ACC;
      S_ACC: begin
        if (k_end) begin
          k_d     = '0;
          state_d = last_q ? S_EMIT : S_IDLE;
        end else begin
          k_d     = k_q + KW'(1);
          state_d = S_READ;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          if (k_end) begin
            state_d = S_IDLE;
          end else begin
            k_d = k_q + KW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      num_q   <= NumCompReset;
      k_q     <= '0;
      n_q     <= NW'(1);
      ov_q    <= 1'b0;
      for (int i = 0; i < MAX_COMPONENTS; i++) begin
        acc_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      n_q     <= n_d;
      if (cfg_valid_i && cfg_ready_o) begin
        num_q <= cfg_data_i;
      end
      if (state_q == S_ACC) begin
        acc_q[k_q] <= acc_new;
      end
      if (out_load && k_end) begin
        for (int i = 0; i < MAX_COMPONENTS; i++) begin
          acc_q[i] <= '0;
        end
      end
      if (out_load) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q   <= base_d;
    weight_q <= weight_d;
    last_q   <= last_d;
    if (state_q == S_MUL) begin
      prod_q <= $signed({{(ProdW-ValueW){ram_rdata[ValueW-1]}}, ram_rdata}) *
                $signed({{(ProdW-ValueW){weight_q[ValueW-1]}}, weight_q});
    end
    if (out_load) begin
      oc_q    <= CompW'(k_q);
      oval_q  <= sat_out;
      olast_q <= k_end;
    end
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {{(OutDataW-CompW-ValueW){1'b0}}, oval_q, oc_q};
  assign m_axis_tlast_o  = olast_q;

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ || state_q == S_EMIT) |-> (NW'(k_q) < n_q))
    else $error("component counter beyond active count");

  a_n_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (n_q != '0 && 32'(n_q) <= MAX_COMPONENTS))
    else $error("active component count out of range");

  a_emit_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |=> m_axis_tvalid_o)
    else $error("emit phase left the output register empty");

endmodule
